FILE: rtl/plsu_pkg.sv
// ----------------------------------------------------------------------------
// Positional list store package
// Field widths, command and status codes, and the control word that is
// broadcast to every cell of the element chain.
// ----------------------------------------------------------------------------
`default_nettype none

package plsu_pkg;

    // Field widths of the request and the result.
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;

    // Packed stream widths; the tdata widths are whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    // Request commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_DELETE   = 3'd1,
        CMD_DEL_VAL  = 3'd2,
        CMD_FIND     = 3'd3,
        CMD_READ     = 3'd4
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_BAD_POS   = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    // Operation that every cell performs in a cycle.
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_DELETE = 3'd2,
        CELL_LOAD   = 3'd3,
        CELL_SHIFT  = 3'd4
    } cell_op_t;

    // Control word broadcast along the chain.
    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   value;
    } cell_ctl_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_SCAN = 2'd2,
        ST_DONE = 2'd3
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/positional_list_store_unit.sv
// ----------------------------------------------------------------------------
// Positional list store unit
// An ordered list of signed 32-bit values held in a chain of cells,
// addressed by 1-based position, with insert, delete, delete by value,
// find and read requests.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_tvalid/s_tready  s_tdata: position, value; s_tuser: cmd
//   m_        out        m_tvalid/m_tready  m_tdata: found_position, read_value,
//                                           count, is_empty, is_full; m_tuser: status
//
// Insert, delete at position and every request rejected without a scan pass
// from acceptance through the execute and done states to the result
// handshake. Find, delete by value and read walk the scan line from the top
// cell down, one cell per cycle, to the matched or requested position, and
// to the bottom cell on a miss. Reset clears the count, the sequencer state and
// the output valid flag; entries need no clearing. A request is taken while
// the previous result waits in the output register; a stalled m_tready holds
// the sequencer before it changes the list.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [6:0] position, [38:7] value, [39] zero
    input  wire logic [plsu_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] cmd
    input  wire logic [plsu_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [6:0] found_position, [38:7] read_value, [45:39] count,
    // [46] is_empty, [47] is_full
    output logic      [plsu_pkg::M_TDATA_W-1:0] m_tdata,
    // [2:0] status
    output logic      [plsu_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    plsu_pkg::cell_ctl_t          cell_ctl;
    logic [IDX_W-1:0]             pos_idx;
    logic [CNT_W-1:0]             cnt;
    logic [plsu_pkg::DATA_W-1:0]  elem     [CAPACITY];
    logic [plsu_pkg::DATA_W-1:0]  scan_val [CAPACITY];
    logic                         scan_match [CAPACITY];

    // Request sequencer and result register.
    plsu_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .scan_top_val   (scan_val[CAPACITY-1]),
        .scan_top_match (scan_match[CAPACITY-1]),
        .cell_ctl       (cell_ctl),
        .pos_idx        (pos_idx),
        .cnt            (cnt)
    );

    // Chain of cells; cell 0 holds position 1.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [plsu_pkg::DATA_W-1:0] prev_elem;
        logic [plsu_pkg::DATA_W-1:0] next_elem;
        logic [plsu_pkg::DATA_W-1:0] prev_scan_val;
        logic                        prev_scan_match;

        if (i == 0) begin : g_first
            assign prev_elem       = elem[i];
            assign prev_scan_val   = '0;
            assign prev_scan_match = 1'b0;
        end else begin : g_inner
            assign prev_elem       = elem[i-1];
            assign prev_scan_val   = scan_val[i-1];
            assign prev_scan_match = scan_match[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign next_elem = elem[i];
        end else begin : g_below
            assign next_elem = elem[i+1];
        end

        plsu_cell #(
            .CELL_IDX (i),
            .IDX_W    (IDX_W),
            .CNT_W    (CNT_W)
        ) u_cell (
            .aclk            (aclk),
            .ctl             (cell_ctl),
            .pos_idx         (pos_idx),
            .cnt             (cnt),
            .prev_elem       (prev_elem),
            .next_elem       (next_elem),
            .prev_scan_val   (prev_scan_val),
            .prev_scan_match (prev_scan_match),
            .elem            (elem[i]),
            .scan_val        (scan_val[i]),
            .scan_match      (scan_match[i])
        );
    end

endmodule

`default_nettype wire

FILE: rtl/plsu_cell.sv
// ----------------------------------------------------------------------------
// Positional list store cell
// Holds one list entry and one stage of the scan line. Inserts take the
// lower neighbor's entry, deletes take the upper neighbor's entry, and the
// scan line moves one stage toward the top of the chain per shift.
// ----------------------------------------------------------------------------
`default_nettype none

module plsu_cell #(
    parameter int CELL_IDX = 0,
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7
) (
    input  wire logic                        aclk,
    input  wire plsu_pkg::cell_ctl_t         ctl,
    input  wire logic [IDX_W-1:0]            pos_idx,
    input  wire logic [CNT_W-1:0]            cnt,
    input  wire logic [plsu_pkg::DATA_W-1:0] prev_elem,
    input  wire logic [plsu_pkg::DATA_W-1:0] next_elem,
    input  wire logic [plsu_pkg::DATA_W-1:0] prev_scan_val,
    input  wire logic                        prev_scan_match,
    output logic      [plsu_pkg::DATA_W-1:0] elem,
    output logic      [plsu_pkg::DATA_W-1:0] scan_val,
    output logic                             scan_match
);

    logic [plsu_pkg::DATA_W-1:0] elem_reg, elem_next;
    logic [plsu_pkg::DATA_W-1:0] scan_val_reg, scan_val_next;
    logic                        scan_match_reg, scan_match_next;
    logic                        above_pos;
    logic                        at_pos;
    logic                        in_list;

    // Where this cell sits relative to the request position and the fill level.
    assign above_pos = IDX_W'(CELL_IDX) > pos_idx;
    assign at_pos    = IDX_W'(CELL_IDX) == pos_idx;
    assign in_list   = CNT_W'(CELL_IDX) < cnt;

    // Entry and scan stage update.
    always_comb begin
        elem_next       = elem_reg;
        scan_val_next   = scan_val_reg;
        scan_match_next = scan_match_reg;
        case (ctl.op)
            plsu_pkg::CELL_INSERT: begin
                if (above_pos) begin
                    elem_next = prev_elem;
                end else if (at_pos) begin
                    elem_next = ctl.value;
                end
            end
            plsu_pkg::CELL_DELETE: begin
                if (above_pos || at_pos) begin
                    elem_next = next_elem;
                end
            end
            plsu_pkg::CELL_LOAD: begin
                scan_val_next   = elem_reg;
                scan_match_next = in_list && (elem_reg == ctl.value);
            end
            plsu_pkg::CELL_SHIFT: begin
                scan_val_next   = prev_scan_val;
                scan_match_next = prev_scan_match;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        elem_reg       <= elem_next;
        scan_val_reg   <= scan_val_next;
        scan_match_reg <= scan_match_next;
    end

    assign elem       = elem_reg;
    assign scan_val   = scan_val_reg;
    assign scan_match = scan_match_reg;

endmodule

`default_nettype wire

FILE: rtl/plsu_ctrl.sv
// ----------------------------------------------------------------------------
// Positional list store sequencer
// Takes requests, checks them against the fill count, drives the cell chain
// through load, scan and update, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module plsu_ctrl #(
    parameter int CAPACITY = 64,
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [plsu_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [plsu_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [plsu_pkg::M_TDATA_W-1:0] m_tdata,
    output logic      [plsu_pkg::M_TUSER_W-1:0] m_tuser,
    input  wire logic [plsu_pkg::DATA_W-1:0]    scan_top_val,
    input  wire logic                           scan_top_match,
    output plsu_pkg::cell_ctl_t                 cell_ctl,
    output logic      [IDX_W-1:0]               pos_idx,
    output logic      [CNT_W-1:0]               cnt
);

    // Wide enough for the position field, the count and count plus one.
    localparam int CMP_W = ((CNT_W > plsu_pkg::POS_W) ? CNT_W : plsu_pkg::POS_W) + 1;

    plsu_pkg::state_t  state_reg, state_next;

    plsu_pkg::cmd_t                 cmd_reg, cmd_next;
    logic [plsu_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [plsu_pkg::DATA_W-1:0]    val_reg, val_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [IDX_W-1:0]               k_reg, k_next;
    logic [IDX_W-1:0]               scan_idx_reg, scan_idx_next;
    logic [plsu_pkg::DATA_W-1:0]    read_reg, read_next;
    plsu_pkg::status_t              status_reg, status_next;
    plsu_pkg::cell_op_t             apply_reg, apply_next;

    logic                           m_valid_reg, m_valid_next;
    plsu_pkg::status_t              o_status_reg, o_status_next;
    logic [plsu_pkg::POS_W-1:0]     o_found_reg, o_found_next;
    logic [plsu_pkg::DATA_W-1:0]    o_read_reg, o_read_next;
    logic [plsu_pkg::POS_W-1:0]     o_count_reg, o_count_next;
    logic                           o_empty_reg, o_empty_next;
    logic                           o_full_reg, o_full_next;

    logic [CMP_W-1:0]               pos_w;
    logic [CMP_W-1:0]               cnt_w;
    logic [CMP_W-1:0]               found_w;
    logic [CMP_W-1:0]               cnt_after_w;
    logic [CNT_W-1:0]               count_after;
    logic                           list_empty;
    logic                           list_full;
    logic                           pos_in_list;
    logic                           pos_for_insert;
    logic                           needs_scan;
    logic                           scan_end;
    logic                           out_free;
    logic                           accept;

    // Checks on the held request.
    assign pos_w          = CMP_W'(pos_reg);
    assign cnt_w          = CMP_W'(count_reg);
    assign list_empty     = count_reg == '0;
    assign list_full      = count_reg == CNT_W'(CAPACITY);
    assign pos_in_list    = (pos_w != '0) && (pos_w <= cnt_w);
    assign pos_for_insert = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));

    assign needs_scan = !list_empty &&
                        ((cmd_reg == plsu_pkg::CMD_READ && pos_in_list) ||
                         cmd_reg == plsu_pkg::CMD_DEL_VAL ||
                         cmd_reg == plsu_pkg::CMD_FIND);

    // A read stops at its position; a search stops at the first hit from the top.
    assign scan_end = (cmd_reg == plsu_pkg::CMD_READ) ? (scan_idx_reg == k_reg)
                                                      : (scan_top_match || scan_idx_reg == '0);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = state_reg == plsu_pkg::ST_IDLE;
    assign accept   = s_tvalid && s_tready;

    // Count after the pending update is applied.
    always_comb begin
        case (apply_reg)
            plsu_pkg::CELL_INSERT: count_after = count_reg + CNT_W'(1);
            plsu_pkg::CELL_DELETE: count_after = count_reg - CNT_W'(1);
            default:               count_after = count_reg;
        endcase
    end

    assign cnt_after_w = CMP_W'(count_after);
    assign found_w     = CMP_W'(k_reg) + CMP_W'(1);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            plsu_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = plsu_pkg::ST_EXEC;
                end
            end
            plsu_pkg::ST_EXEC: begin
                state_next = needs_scan ? plsu_pkg::ST_SCAN : plsu_pkg::ST_DONE;
            end
            plsu_pkg::ST_SCAN: begin
                if (scan_end) begin
                    state_next = plsu_pkg::ST_DONE;
                end
            end
            plsu_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = plsu_pkg::ST_IDLE;
                end
            end
            default: state_next = plsu_pkg::ST_IDLE;
        endcase
    end

    // Datapath and chain control.
    always_comb begin
        cmd_next      = cmd_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        count_next    = count_reg;
        k_next        = k_reg;
        scan_idx_next = scan_idx_reg;
        read_next     = read_reg;
        status_next   = status_reg;
        apply_next    = apply_reg;

        m_valid_next  = m_valid_reg && !m_tready;
        o_status_next = o_status_reg;
        o_found_next  = o_found_reg;
        o_read_next   = o_read_reg;
        o_count_next  = o_count_reg;
        o_empty_next  = o_empty_reg;
        o_full_next   = o_full_reg;

        cell_ctl.op    = plsu_pkg::CELL_HOLD;
        cell_ctl.value = val_reg;

        unique case (state_reg)
            plsu_pkg::ST_IDLE: begin
                if (accept) begin
                    cmd_next = plsu_pkg::cmd_t'(s_tuser[plsu_pkg::CMD_W-1:0]);
                    pos_next = s_tdata[plsu_pkg::POS_W-1:0];
                    val_next = s_tdata[plsu_pkg::POS_W +: plsu_pkg::DATA_W];
                end
            end
            plsu_pkg::ST_EXEC: begin
                k_next        = IDX_W'(pos_w - CMP_W'(1));
                scan_idx_next = IDX_W'(CAPACITY - 1);
                read_next     = '0;
                apply_next    = plsu_pkg::CELL_HOLD;
                status_next   = plsu_pkg::STAT_OK;
                case (cmd_reg) inside
                    plsu_pkg::CMD_INSERT: begin
                        if (list_full) begin
                            status_next = plsu_pkg::STAT_FULL;
                        end else if (!pos_for_insert) begin
                            status_next = plsu_pkg::STAT_BAD_POS;
                        end else begin
                            apply_next = plsu_pkg::CELL_INSERT;
                        end
                    end
                    plsu_pkg::CMD_DELETE: begin
                        if (list_empty) begin
                            status_next = plsu_pkg::STAT_EMPTY;
                        end else if (!pos_in_list) begin
                            status_next = plsu_pkg::STAT_BAD_POS;
                        end else begin
                            apply_next = plsu_pkg::CELL_DELETE;
                        end
                    end
                    plsu_pkg::CMD_DEL_VAL, plsu_pkg::CMD_FIND: begin
                        if (list_empty) begin
                            status_next = plsu_pkg::STAT_NOT_FOUND;
                        end
                    end
                    plsu_pkg::CMD_READ: begin
                        if (list_empty) begin
                            status_next = plsu_pkg::STAT_EMPTY;
                        end else if (!pos_in_list) begin
                            status_next = plsu_pkg::STAT_BAD_POS;
                        end
                    end
                    default: begin
                        status_next = plsu_pkg::STAT_BAD_POS;
                    end
                endcase
                if (needs_scan) begin
                    cell_ctl.op = plsu_pkg::CELL_LOAD;
                end
            end
            plsu_pkg::ST_SCAN: begin
                if (!scan_end) begin
                    cell_ctl.op   = plsu_pkg::CELL_SHIFT;
                    scan_idx_next = scan_idx_reg - IDX_W'(1);
                end else if (cmd_reg == plsu_pkg::CMD_READ) begin
                    read_next = scan_top_val;
                end else if (scan_top_match) begin
                    k_next = scan_idx_reg;
                    if (cmd_reg == plsu_pkg::CMD_DEL_VAL) begin
                        apply_next = plsu_pkg::CELL_DELETE;
                    end
                end else begin
                    status_next = plsu_pkg::STAT_NOT_FOUND;
                end
            end
            plsu_pkg::ST_DONE: begin
                if (out_free) begin
                    cell_ctl.op   = apply_reg;
                    count_next    = count_after;
                    m_valid_next  = 1'b1;
                    o_status_next = status_reg;
                    o_found_next  = ((cmd_reg == plsu_pkg::CMD_DEL_VAL ||
                                      cmd_reg == plsu_pkg::CMD_FIND) &&
                                     status_reg == plsu_pkg::STAT_OK)
                                    ? found_w[plsu_pkg::POS_W-1:0] : '0;
                    o_read_next   = (cmd_reg == plsu_pkg::CMD_READ &&
                                     status_reg == plsu_pkg::STAT_OK) ? read_reg : '0;
                    o_count_next  = cnt_after_w[plsu_pkg::POS_W-1:0];
                    o_empty_next  = count_after == '0;
                    o_full_next   = count_after == CNT_W'(CAPACITY);
                end
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= plsu_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request and result payload.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        k_reg        <= k_next;
        scan_idx_reg <= scan_idx_next;
        read_reg     <= read_next;
        status_reg   <= status_next;
        apply_reg    <= apply_next;
        o_status_reg <= o_status_next;
        o_found_reg  <= o_found_next;
        o_read_reg   <= o_read_next;
        o_count_reg  <= o_count_next;
        o_empty_reg  <= o_empty_next;
        o_full_reg   <= o_full_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = {o_full_reg, o_empty_reg, o_count_reg, o_read_reg, o_found_reg};
    assign pos_idx  = k_reg;
    assign cnt      = count_reg;

endmodule

`default_nettype wire
